// File: sv/sm3_pkg.sv
package sm3_pkg;

    localparam int WORD_W      = 32;
    localparam int BCNT_W      = 3;
    localparam int DIDX_W      = 3;
    localparam int DIGEST_WORDS = 8;
    localparam int BLOCK_BITS  = 512;
    localparam int LEN_BITS    = 61;

    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [6:0] BLOCK_BYTES = 7'd64;
    localparam logic [2:0] MAX_WORD_BYTES = 3'd4;
    localparam logic [DIDX_W-1:0] LAST_INDEX = 3'd7;

    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [31:0] T_LOW    = 32'h79cc4519;
    localparam logic [31:0] T_HIGH   = 32'h7a879d8a;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        return (x << n) | (x >> (6'd32 - {1'b0, n}));
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
    endfunction

    // Round constant already rotated by the round number.
    function automatic logic [31:0] round_const(input logic [5:0] j);
        return rotl32((j[5:4] == 2'b00) ? T_LOW : T_HIGH, j[4:0]);
    endfunction

    function automatic logic [31:0] sm3_iv(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h7380166f;
            3'd1:    v = 32'h4914b2b9;
            3'd2:    v = 32'h172442d7;
            3'd3:    v = 32'hda8a0600;
            3'd4:    v = 32'ha96f30bc;
            3'd5:    v = 32'h163138aa;
            3'd6:    v = 32'he38dee4d;
            default: v = 32'hb0fb0e4e;
        endcase
        return v;
    endfunction

endpackage

// File: sv/sm3_msg_if.sv
interface sm3_msg_if;
    import sm3_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] msg_word;
    logic [BCNT_W-1:0] word_bytes;
    logic              is_last;

    modport source (output valid, output msg_word, output word_bytes, output is_last,
                    input ready);
    modport sink   (input valid, input msg_word, input word_bytes, input is_last,
                    output ready);
endinterface

// File: sv/sm3_digest_if.sv
interface sm3_digest_if;
    import sm3_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] digest_word;
    logic [DIDX_W-1:0] digest_index;
    logic              digest_last;

    modport source (output valid, output digest_word, output digest_index,
                    output digest_last, input ready);
    modport sink   (input valid, input digest_word, input digest_index,
                    input digest_last, output ready);
endinterface

// File: sv/sm3_hash_engine.sv
// SM3 hash engine with a 256-bit digest.
// The msg channel carries message bytes packed big-endian into 32-bit words,
// a byte count (values above four count as four) and a last flag. A word is
// taken while the engine waits for input; each time 64 bytes have gathered,
// one round unit runs the 64 compression rounds, one round per cycle, and
// the engine takes no input until the compression is done.
// After the word marked last the engine pads the message (0x80, zero bytes,
// the 64-bit bit length), the zero bytes up to four a cycle, and runs one
// or two further compressions.
// The digest channel then gives eight transactions, index 0 first, one per
// cycle while the receiver is ready, from an output register; index 7
// carries the last flag. Once the eighth word sits in that register the
// engine accepts the next message, while a stalled receiver simply holds
// the register and the engine waits before its next digest.
// Reset loads the initial value and clears the length and byte counters; no
// clearing pass is needed.
module sm3_hash_engine (
    input  logic         clk,
    input  logic         rst_n,
    sm3_msg_if.sink      msg,
    sm3_digest_if.source digest
);
    import sm3_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DATA,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_ROUNDS,
        ST_DIGEST
    } state_t;

    state_t                  state_reg, state_next;
    state_t                  ret_reg, ret_next;
    logic [5:0]              fill_reg, fill_next;
    logic [LEN_BITS-1:0]     len_reg, len_next;
    logic [5:0]              round_reg, round_next;
    logic [DIDX_W-1:0]       didx_reg, didx_next;
    logic [WORD_W-1:0]       chain_reg [DIGEST_WORDS];
    logic [WORD_W-1:0]       chain_next [DIGEST_WORDS];
    logic [WORD_W-1:0]       work_reg [DIGEST_WORDS];
    logic [WORD_W-1:0]       work_next [DIGEST_WORDS];
    logic                    out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]       out_word_reg, out_word_next;
    logic [DIDX_W-1:0]       out_index_reg, out_index_next;
    logic                    out_last_reg, out_last_next;
    logic [BLOCK_BITS-1:0]   blk_reg, blk_next;
    logic [WORD_W-1:0]       hold_word_reg, hold_word_next;
    logic [BCNT_W-1:0]       hold_cnt_reg, hold_cnt_next;
    logic                    hold_last_reg, hold_last_next;

    logic                    accept;
    logic                    out_free;

    // Byte push path
    logic [WORD_W-1:0]       push_src;
    logic [BCNT_W-1:0]       push_cnt;
    logic                    push_last;
    logic [6:0]              push_lim;
    logic [6:0]              room;
    logic [BCNT_W-1:0]       push_n;
    logic [6:0]              fill_sum;
    logic                    blk_full;
    logic [BLOCK_BITS-1:0]   push_blk;
    logic [WORD_W-1:0]       left_word;
    logic [BCNT_W-1:0]       left_cnt;
    logic                    left_any;

    // Round unit
    logic [WORD_W-1:0]       w0, w3, w4, w7, w10, w13, w_new;
    logic [WORD_W-1:0]       a12, ss1, ss2, ff, gg, tt1, tt2;
    logic [WORD_W-1:0]       rnd_out [DIGEST_WORDS];

    assign accept    = msg.valid & msg.ready;
    assign out_free  = !out_valid_reg || digest.ready;
    assign msg.ready = (state_reg == ST_IDLE);

    assign digest.valid        = out_valid_reg;
    assign digest.digest_word  = out_word_reg;
    assign digest.digest_index = out_index_reg;
    assign digest.digest_last  = out_last_reg;

    assign room = BLOCK_BYTES - {1'b0, fill_reg};

    always_comb
    begin
        push_src  = '0;
        push_cnt  = '0;
        push_last = hold_last_reg;
        push_lim  = room;
        case (state_reg)
            ST_IDLE:
            begin
                push_src  = msg.msg_word;
                push_cnt  = (msg.word_bytes > MAX_WORD_BYTES) ? MAX_WORD_BYTES : msg.word_bytes;
                push_last = msg.is_last;
            end
            ST_DATA:
            begin
                push_src = hold_word_reg;
                push_cnt = hold_cnt_reg;
            end
            ST_PAD_MARK:
            begin
                push_src = {PAD_BYTE, 24'h000000};
                push_cnt = 3'd1;
            end
            ST_PAD_ZERO:
            begin
                push_cnt = MAX_WORD_BYTES;
                // Zero bytes stop at the length field, or run to the block end first.
                if (fill_reg < LEN_POS)
                    push_lim = {1'b0, LEN_POS} - {1'b0, fill_reg};
            end
            default:
            begin
                push_cnt = '0;
            end
        endcase
    end

    assign push_n   = ({4'b0, push_cnt} > push_lim) ? push_lim[BCNT_W-1:0] : push_cnt;
    assign fill_sum = {1'b0, fill_reg} + {4'b0, push_n};
    assign blk_full = (fill_sum == BLOCK_BYTES);
    assign left_cnt = push_cnt - push_n;
    assign left_any = (left_cnt != '0);

    always_comb
    begin
        case (push_n)
            3'd1:
            begin
                push_blk  = {blk_reg[BLOCK_BITS-9:0], push_src[31:24]};
                left_word = {push_src[23:0], 8'h00};
            end
            3'd2:
            begin
                push_blk  = {blk_reg[BLOCK_BITS-17:0], push_src[31:16]};
                left_word = {push_src[15:0], 16'h0000};
            end
            3'd3:
            begin
                push_blk  = {blk_reg[BLOCK_BITS-25:0], push_src[31:8]};
                left_word = {push_src[7:0], 24'h000000};
            end
            3'd4:
            begin
                push_blk  = {blk_reg[BLOCK_BITS-33:0], push_src};
                left_word = '0;
            end
            default:
            begin
                push_blk  = blk_reg;
                left_word = push_src;
            end
        endcase
    end

    // The block register doubles as the 16-word message expansion window.
    assign w0  = blk_reg[BLOCK_BITS-1   -: WORD_W];
    assign w3  = blk_reg[BLOCK_BITS-97  -: WORD_W];
    assign w4  = blk_reg[BLOCK_BITS-129 -: WORD_W];
    assign w7  = blk_reg[BLOCK_BITS-225 -: WORD_W];
    assign w10 = blk_reg[BLOCK_BITS-321 -: WORD_W];
    assign w13 = blk_reg[BLOCK_BITS-417 -: WORD_W];
    assign w_new = perm1(w0 ^ w7 ^ rotl32(w13, 5'd15)) ^ rotl32(w3, 5'd7) ^ w10;

    always_comb
    begin
        a12 = rotl32(work_reg[0], 5'd12);
        ss1 = rotl32(a12 + work_reg[4] + round_const(round_reg), 5'd7);
        ss2 = ss1 ^ a12;
        if (round_reg[5:4] == 2'b00)
        begin
            ff = work_reg[0] ^ work_reg[1] ^ work_reg[2];
            gg = work_reg[4] ^ work_reg[5] ^ work_reg[6];
        end
        else
        begin
            ff = (work_reg[0] & work_reg[1]) | (work_reg[0] & work_reg[2])
               | (work_reg[1] & work_reg[2]);
            gg = (work_reg[4] & work_reg[5]) | (~work_reg[4] & work_reg[6]);
        end
        tt1 = ff + work_reg[3] + ss2 + (w0 ^ w4);
        tt2 = gg + work_reg[7] + ss1 + w0;
        rnd_out[0] = tt1;
        rnd_out[1] = work_reg[0];
        rnd_out[2] = rotl32(work_reg[1], 5'd9);
        rnd_out[3] = work_reg[2];
        rnd_out[4] = perm0(tt2);
        rnd_out[5] = work_reg[4];
        rnd_out[6] = rotl32(work_reg[5], 5'd19);
        rnd_out[7] = work_reg[6];
    end

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        fill_next      = fill_reg;
        len_next       = len_reg;
        round_next     = round_reg;
        didx_next      = didx_reg;
        chain_next     = chain_reg;
        work_next      = work_reg;
        out_valid_next = out_valid_reg & ~digest.ready;
        out_word_next  = out_word_reg;
        out_index_next = out_index_reg;
        out_last_next  = out_last_reg;
        blk_next       = blk_reg;
        hold_word_next = hold_word_reg;
        hold_cnt_next  = hold_cnt_reg;
        hold_last_next = hold_last_reg;

        unique case (state_reg)
            ST_IDLE, ST_DATA:
            begin
                if (state_reg == ST_DATA || accept)
                begin
                    blk_next       = push_blk;
                    hold_word_next = left_word;
                    hold_cnt_next  = left_cnt;
                    hold_last_next = push_last;
                    len_next       = len_reg + {{(LEN_BITS-BCNT_W){1'b0}}, push_n};
                    if (blk_full)
                    begin
                        fill_next  = '0;
                        round_next = '0;
                        state_next = ST_ROUNDS;
                        ret_next   = left_any ? ST_DATA : (push_last ? ST_PAD_MARK : ST_IDLE);
                    end
                    else
                    begin
                        fill_next  = fill_sum[5:0];
                        state_next = left_any ? ST_DATA : (push_last ? ST_PAD_MARK : ST_IDLE);
                    end
                end
            end
            ST_PAD_MARK, ST_PAD_ZERO:
            begin
                if (state_reg == ST_PAD_ZERO && fill_reg == LEN_POS)
                begin
                    state_next = ST_PAD_LEN;
                end
                else
                begin
                    blk_next = push_blk;
                    if (blk_full)
                    begin
                        fill_next  = '0;
                        round_next = '0;
                        state_next = ST_ROUNDS;
                        ret_next   = ST_PAD_ZERO;
                    end
                    else
                    begin
                        fill_next  = fill_sum[5:0];
                        state_next = ST_PAD_ZERO;
                    end
                end
            end
            ST_PAD_LEN:
            begin
                blk_next   = {blk_reg[BLOCK_BITS-65:0], len_reg, 3'b000};
                len_next   = '0;
                fill_next  = '0;
                round_next = '0;
                state_next = ST_ROUNDS;
                ret_next   = ST_DIGEST;
            end
            ST_ROUNDS:
            begin
                blk_next   = {blk_reg[BLOCK_BITS-33:0], w_new};
                round_next = round_reg + 6'd1;
                if (round_reg == LAST_ROUND)
                begin
                    for (int i = 0; i < DIGEST_WORDS; i++)
                    begin
                        chain_next[i] = chain_reg[i] ^ rnd_out[i];
                        work_next[i]  = chain_reg[i] ^ rnd_out[i];
                    end
                    state_next = ret_reg;
                end
                else
                begin
                    work_next = rnd_out;
                end
            end
            ST_DIGEST:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = chain_reg[didx_reg];
                    out_index_next = didx_reg;
                    out_last_next  = (didx_reg == LAST_INDEX);
                    didx_next      = didx_reg + 3'd1;
                    if (didx_reg == LAST_INDEX)
                    begin
                        for (int i = 0; i < DIGEST_WORDS; i++)
                        begin
                            chain_next[i] = sm3_iv(3'(i));
                            work_next[i]  = sm3_iv(3'(i));
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            fill_reg      <= '0;
            len_reg       <= '0;
            round_reg     <= '0;
            didx_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
            out_index_reg <= '0;
            out_last_reg  <= 1'b0;
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                chain_reg[i] <= sm3_iv(3'(i));
                work_reg[i]  <= sm3_iv(3'(i));
            end
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            round_reg     <= round_next;
            didx_reg      <= didx_next;
            out_valid_reg <= out_valid_next;
            out_word_reg  <= out_word_next;
            out_index_reg <= out_index_next;
            out_last_reg  <= out_last_next;
            chain_reg     <= chain_next;
            work_reg      <= work_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg       <= blk_next;
        hold_word_reg <= hold_word_next;
        hold_cnt_reg  <= hold_cnt_next;
        hold_last_reg <= hold_last_next;
    end

`ifndef SYNTHESIS
    // A compression only starts on a complete block, so the byte count is back at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUNDS) |-> (fill_reg == '0))
        else $error("byte count not cleared during compression");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAD_LEN) |-> (fill_reg == LEN_POS))
        else $error("length field not aligned to the end of the block");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUNDS && round_reg != LAST_ROUND) |=> (state_reg == ST_ROUNDS))
        else $error("compression left before the last round");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGEST && out_free && didx_reg == LAST_INDEX)
        |=> (state_reg == ST_IDLE && chain_reg[0] == sm3_iv(3'd0) && out_last_reg))
        else $error("chaining value not restored after the digest");

    assert property (@(posedge clk) disable iff (!rst_n)
        digest.valid |-> (digest.digest_last == (digest.digest_index == LAST_INDEX)))
        else $error("last flag does not match the digest index");
`endif

endmodule
